### rtl/scfh_pkg.sv
package scfh_pkg;

    localparam logic [7:0] CMD_QUERY    = 8'hFA;
    localparam logic [7:0] CMD_MOTOR    = 8'hF8;
    localparam logic [7:0] CMD_LAMPS    = 8'hF7;
    localparam logic [7:0] CMD_CHECK    = 8'hF1;
    localparam logic [7:0] CMD_SHUTDOWN = 8'hF2;
    localparam logic [7:0] CMD_RESET    = 8'hF3;

    localparam logic [7:0] CHECK_MASK   = 8'h7F;
    localparam logic [7:0] KEY_BYTE     = 8'h72;
    localparam logic [7:0] FILL_BYTE    = 8'hFF;
    localparam logic [7:0] FAULT_FLAG   = 8'h10;
    localparam logic [7:0] WARN_FLAG    = 8'h80;

    localparam logic [1:0] CODE_ZERO = 2'd0;
    localparam logic [1:0] CODE_ONE  = 2'd1;
    localparam logic [1:0] CODE_TWO  = 2'd2;
    localparam logic [1:0] CODE_KEEP = 2'd3;

    localparam int unsigned FRAME_LEN = 6;
    localparam logic [2:0]  LAST_IDX  = 3'(FRAME_LEN - 1);

    typedef struct packed {
        logic [7:0] frame_head;
        logic [7:0] frame_arg1;
        logic [7:0] frame_arg2;
        logic [7:0] frame_arg3;
        logic [7:0] frame_arg4;
        logic       gate1_sensor;
        logic       gate2_sensor;
    } t_in;

    typedef struct packed {
        logic [7:0]  reply_byte;
        logic        byte_valid;
        logic        frame_last;
        logic        shutdown_request;
        logic        reset_request;
        logic [15:0] status_word;
    } t_out;

    typedef struct packed {
        logic       motor_forward;
        logic       motor_backward;
        logic       gate1_enable;
        logic       gate2_enable;
        logic       xray_lamp;
        logic       warning_lamp;
        logic [1:0] self_check_faults;
    } t_state;

    typedef struct packed {
        logic [FRAME_LEN-1:0][7:0] bytes;
        logic                      silent;
        logic                      shutdown_request;
        logic                      reset_request;
        logic [15:0]               status_word;
    } t_frame;

endpackage

### rtl/scfh_cmd_decode.sv
module scfh_cmd_decode (
    input  scfh_pkg::t_in    i_cmd,
    input  scfh_pkg::t_state i_state,
    output scfh_pkg::t_state o_state,
    output scfh_pkg::t_frame o_frame
);
    import scfh_pkg::*;

    t_state                    ns;
    logic [7:0]                d0;
    logic [7:0]                d1;
    logic [7:0]                d2;
    logic [7:0]                chk;
    logic [7:0]                lo;
    logic [7:0]                hi;
    logic                      s1;
    logic                      s2;
    logic                      silent;
    logic                      shut_req;
    logic                      rst_req;
    logic [FRAME_LEN-1:0][7:0] frame_bytes;

    assign s1 = i_cmd.gate1_sensor;
    assign s2 = i_cmd.gate2_sensor;

    always_comb begin
        ns = i_state;
        d0 = 8'h00;
        d1 = 8'h00;
        d2 = 8'h00;
        silent   = 1'b0;
        shut_req = 1'b0;
        rst_req  = 1'b0;
        case (i_cmd.frame_head)
            CMD_QUERY: begin
                d0 = {6'd0, i_state.motor_backward, i_state.motor_forward};
                d1 = {4'd0, s2, s1, i_state.gate2_enable, i_state.gate1_enable};
                d2 = {6'd0, i_state.warning_lamp, i_state.xray_lamp};
                if (i_state.self_check_faults != 2'd0) begin
                    d2 = d2 | FAULT_FLAG;
                end
            end
            CMD_MOTOR: begin
                case (i_cmd.frame_arg1[1:0])
                    CODE_ZERO: begin
                        ns.motor_forward  = 1'b0;
                        ns.motor_backward = 1'b0;
                        d0 = 8'd0;
                    end
                    CODE_ONE: begin
                        ns.motor_forward  = 1'b1;
                        ns.motor_backward = 1'b0;
                        d0 = 8'd1;
                    end
                    CODE_TWO: begin
                        ns.motor_forward  = 1'b0;
                        ns.motor_backward = 1'b1;
                        d0 = 8'd2;
                    end
                    default: begin
                        d0 = i_state.motor_forward ? 8'd1 :
                             (i_state.motor_backward ? 8'd2 : 8'd0);
                    end
                endcase
                case (i_cmd.frame_arg2[1:0])
                    CODE_ZERO: begin
                        ns.gate1_enable = 1'b0;
                        ns.gate2_enable = 1'b0;
                        d1 = 8'd0;
                    end
                    CODE_ONE: begin
                        ns.gate1_enable = 1'b1;
                        ns.gate2_enable = 1'b0;
                        d1 = 8'd1;
                    end
                    CODE_TWO: begin
                        ns.gate1_enable = 1'b0;
                        ns.gate2_enable = 1'b1;
                        d1 = 8'd2;
                    end
                    default: begin
                        d1 = {6'd0, i_state.gate2_enable, i_state.gate1_enable};
                    end
                endcase
            end
            CMD_LAMPS: begin
                case (i_cmd.frame_arg1[1:0])
                    CODE_ONE:  ns.xray_lamp = 1'b0;
                    CODE_KEEP: ns.xray_lamp = 1'b1;
                    default:   ns.xray_lamp = i_state.xray_lamp;
                endcase
                case (i_cmd.frame_arg2[1:0])
                    CODE_ONE:  ns.warning_lamp = 1'b0;
                    CODE_KEEP: ns.warning_lamp = 1'b1;
                    default:   ns.warning_lamp = i_state.warning_lamp;
                endcase
                d0 = {7'd0, ns.xray_lamp};
                d1 = {7'd0, ns.warning_lamp};
            end
            CMD_CHECK: begin
                ns.self_check_faults = {s2, s1};
                if (s1 || s2) begin
                    ns.warning_lamp   = 1'b1;
                    ns.motor_forward  = 1'b0;
                    ns.motor_backward = 1'b0;
                end
                ns.gate1_enable = 1'b0;
                ns.gate2_enable = 1'b0;
                d1 = {6'd0, s2, s1};
            end
            CMD_SHUTDOWN: begin
                shut_req = (i_cmd.frame_arg1 == 8'h00) &&
                           (i_cmd.frame_arg2 == 8'h00) &&
                           (i_cmd.frame_arg3 == 8'h00) &&
                           (i_cmd.frame_arg4 == KEY_BYTE);
                silent = 1'b1;
            end
            CMD_RESET: begin
                rst_req = (i_cmd.frame_arg1 == 8'h01) &&
                          (i_cmd.frame_arg2 == 8'h02) &&
                          (i_cmd.frame_arg3 == 8'h03) &&
                          (i_cmd.frame_arg4 == KEY_BYTE);
                silent = !rst_req;
            end
            default: begin
            end
        endcase
    end

    assign chk = (i_cmd.frame_head ^ d0 ^ d1 ^ d2) & CHECK_MASK;

    always_comb begin
        case (i_cmd.frame_head)
            CMD_RESET: begin
                frame_bytes = {FILL_BYTE, KEY_BYTE, 8'h03, 8'h02, 8'h01, CMD_RESET};
            end
            CMD_QUERY, CMD_MOTOR, CMD_LAMPS, CMD_CHECK: begin
                frame_bytes = {FILL_BYTE, chk, d2, d1, d0, i_cmd.frame_head};
            end
            default: begin
                frame_bytes = {FRAME_LEN{FILL_BYTE}};
            end
        endcase
    end

    assign lo = {ns.warning_lamp, ns.xray_lamp, s2, s1,
                 ns.gate2_enable, ns.gate1_enable, ns.motor_backward, ns.motor_forward};
    assign hi = ns.warning_lamp ? (WARN_FLAG | ~lo) : lo;

    assign o_frame = {frame_bytes, silent, shut_req, rst_req, hi, lo};
    assign o_state = ns;

endmodule

### rtl/scanner_command_frame_handler.sv
// A command is decoded into the holding register r_pend at its transfer and moves on to
// the output register r_cur once it is free; reply bytes are offered from r_cur.
// Throughput: one reply byte per cycle unless the output stalls; a command yields six
// reply bytes, or one silent transfer for a shutdown or a rejected reset; a new command
// is taken whenever the holding register is empty or hands its frame on in that cycle.
// Synchronous active-low reset clears all control state and drops any frame in flight.
module scanner_command_frame_handler (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  scfh_pkg::t_in    i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output scfh_pkg::t_out   o_out_data
);
    import scfh_pkg::*;

    t_state     r_state;
    t_state     n_state;
    t_frame     n_frame;
    t_frame     r_pend;
    logic       r_pend_valid;
    t_frame     r_cur;
    logic       r_cur_valid;
    logic [2:0] r_idx;
    logic       in_fire;
    logic       out_fire;
    logic       is_last;
    logic       cur_free;

    scfh_cmd_decode u_decode (
        .i_cmd   (i_in_data),
        .i_state (r_state),
        .o_state (n_state),
        .o_frame (n_frame)
    );

    assign o_in_stall = r_pend_valid && !cur_free;
    assign in_fire    = i_in_valid && !o_in_stall;
    assign is_last    = r_cur.silent || (r_idx == LAST_IDX);
    assign out_fire   = r_cur_valid && !i_out_stall;
    assign cur_free   = !r_cur_valid || (out_fire && is_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= '0;
            r_pend_valid <= 1'b0;
            r_cur_valid  <= 1'b0;
            r_idx        <= 3'd0;
        end else begin
            if (in_fire) begin
                r_state <= n_state;
            end
            if (cur_free) begin
                r_cur_valid <= r_pend_valid;
                r_idx       <= 3'd0;
            end else if (out_fire) begin
                r_idx <= r_idx + 3'd1;
            end
            if (in_fire) begin
                r_pend_valid <= 1'b1;
            end else if (cur_free) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_pend <= n_frame;
        end
        if (cur_free && r_pend_valid) begin
            r_cur <= r_pend;
        end
    end

    assign o_out_valid                 = r_cur_valid;
    assign o_out_data.reply_byte       = r_cur.silent ? 8'h00 : r_cur.bytes[r_idx];
    assign o_out_data.byte_valid       = !r_cur.silent;
    assign o_out_data.frame_last       = is_last;
    assign o_out_data.shutdown_request = r_cur.shutdown_request;
    assign o_out_data.reset_request    = r_cur.reset_request;
    assign o_out_data.status_word      = r_cur.status_word;

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import scfh_pkg::*;

    localparam logic [23:0] SHUTDOWN_KEY = 24'h000000;
    localparam logic [23:0] RESET_KEY    = 24'h010203;
    localparam int unsigned RANDOM_CMDS  = 105;
    localparam int unsigned QUIET_LIMIT  = 2000;
    localparam int unsigned TAIL_CYCLES  = 20;
    localparam int unsigned CALM_TAIL    = 20;

    typedef struct {
        t_in cmd;
        bit  drain_first;
    } t_cmd_slot;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    t_in  i_in_data = '0;
    logic i_out_stall = 1'b0;
    logic o_in_stall;
    logic o_out_valid;
    t_out o_out_data;

    t_cmd_slot   cmd_backlog[$];
    t_out        pending_replies[$];
    t_state      scanner;
    bit          in_fired = 1'b0;
    bit          out_fired = 1'b0;
    int unsigned in_gap = 0;
    int unsigned out_gap = 0;
    int unsigned total_cmds = 0;
    int unsigned cmds_taken = 0;
    int unsigned replies_seen = 0;
    int unsigned quiet_cycles = 0;
    int unsigned mismatch_cnt = 0;
    int unsigned shutdown_cnt = 0;
    int unsigned reset_cnt = 0;
    int unsigned fault_cnt = 0;
    int unsigned unknown_cnt = 0;

    scanner_command_frame_handler dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic predict_reply(input t_in cmd);
        logic [7:0] d0, d1, d2, lo, hi;
        logic [7:0] frame [FRAME_LEN];
        logic       shut, rst, silent, known;
        t_out       r;
        d0 = '0;
        d1 = '0;
        d2 = '0;
        shut = 1'b0;
        rst = 1'b0;
        silent = 1'b0;
        known = 1'b1;
        case (cmd.frame_head)
            CMD_QUERY: begin
                d0 = {6'b0, scanner.motor_backward, scanner.motor_forward};
                d1 = {4'b0, cmd.gate2_sensor, cmd.gate1_sensor,
                      scanner.gate2_enable, scanner.gate1_enable};
                d2 = {6'b0, scanner.warning_lamp, scanner.xray_lamp};
                if (scanner.self_check_faults != 2'b00) begin
                    d2 = d2 | FAULT_FLAG;
                end
            end
            CMD_MOTOR: begin
                case (cmd.frame_arg1[1:0])
                    CODE_ZERO: {scanner.motor_forward, scanner.motor_backward} = 2'b00;
                    CODE_ONE:  {scanner.motor_forward, scanner.motor_backward} = 2'b10;
                    CODE_TWO:  {scanner.motor_forward, scanner.motor_backward} = 2'b01;
                    default: ;
                endcase
                d0 = scanner.motor_forward ? 8'd1 : (scanner.motor_backward ? 8'd2 : 8'd0);
                case (cmd.frame_arg2[1:0])
                    CODE_ZERO: {scanner.gate2_enable, scanner.gate1_enable} = 2'b00;
                    CODE_ONE:  {scanner.gate2_enable, scanner.gate1_enable} = 2'b01;
                    CODE_TWO:  {scanner.gate2_enable, scanner.gate1_enable} = 2'b10;
                    default: ;
                endcase
                d1 = {6'b0, scanner.gate2_enable, scanner.gate1_enable};
            end
            CMD_LAMPS: begin
                if (cmd.frame_arg1[1:0] == CODE_ONE) begin
                    scanner.xray_lamp = 1'b0;
                end else if (cmd.frame_arg1[1:0] == CODE_KEEP) begin
                    scanner.xray_lamp = 1'b1;
                end
                if (cmd.frame_arg2[1:0] == CODE_ONE) begin
                    scanner.warning_lamp = 1'b0;
                end else if (cmd.frame_arg2[1:0] == CODE_KEEP) begin
                    scanner.warning_lamp = 1'b1;
                end
                d0 = {7'b0, scanner.xray_lamp};
                d1 = {7'b0, scanner.warning_lamp};
            end
            CMD_CHECK: begin
                scanner.self_check_faults = {cmd.gate2_sensor, cmd.gate1_sensor};
                if (cmd.gate1_sensor || cmd.gate2_sensor) begin
                    scanner.warning_lamp = 1'b1;
                    scanner.motor_forward = 1'b0;
                    scanner.motor_backward = 1'b0;
                    fault_cnt++;
                end
                scanner.gate1_enable = 1'b0;
                scanner.gate2_enable = 1'b0;
                d1 = {6'b0, scanner.self_check_faults};
            end
            CMD_SHUTDOWN: begin
                shut = ({cmd.frame_arg1, cmd.frame_arg2, cmd.frame_arg3} == SHUTDOWN_KEY) &&
                       (cmd.frame_arg4 == KEY_BYTE);
                silent = 1'b1;
                shutdown_cnt += shut;
            end
            CMD_RESET: begin
                rst = ({cmd.frame_arg1, cmd.frame_arg2, cmd.frame_arg3} == RESET_KEY) &&
                      (cmd.frame_arg4 == KEY_BYTE);
                silent = !rst;
                reset_cnt += rst;
            end
            default: begin
                known = 1'b0;
                unknown_cnt++;
            end
        endcase

        lo = {scanner.warning_lamp, scanner.xray_lamp, cmd.gate2_sensor, cmd.gate1_sensor,
              scanner.gate2_enable, scanner.gate1_enable,
              scanner.motor_backward, scanner.motor_forward};
        hi = scanner.warning_lamp ? (WARN_FLAG | ~lo) : lo;
        r.shutdown_request = shut;
        r.reset_request = rst;
        r.status_word = {hi, lo};

        if (silent) begin
            r.reply_byte = '0;
            r.byte_valid = 1'b0;
            r.frame_last = 1'b1;
            pending_replies.push_back(r);
        end else begin
            if (cmd.frame_head == CMD_RESET) begin
                {frame[0], frame[1], frame[2], frame[3], frame[4]} =
                    {CMD_RESET, RESET_KEY, KEY_BYTE};
            end else if (known) begin
                {frame[0], frame[1], frame[2], frame[3]} = {cmd.frame_head, d0, d1, d2};
                frame[4] = (cmd.frame_head ^ d0 ^ d1 ^ d2) & CHECK_MASK;
            end else begin
                for (int k = 0; k < 5; k++) begin
                    frame[k] = FILL_BYTE;
                end
            end
            frame[FRAME_LEN-1] = FILL_BYTE;
            for (int k = 0; k < FRAME_LEN; k++) begin
                r.reply_byte = frame[k];
                r.byte_valid = 1'b1;
                r.frame_last = (k == FRAME_LEN - 1);
                pending_replies.push_back(r);
            end
        end
    endtask

    task automatic queue_cmd(input logic [7:0] head, input logic [31:0] args,
                             input logic [1:0] sensors, input bit drain = 1'b0);
        t_cmd_slot slot;
        slot.cmd.frame_head = head;
        {slot.cmd.frame_arg1, slot.cmd.frame_arg2, slot.cmd.frame_arg3,
         slot.cmd.frame_arg4} = args;
        {slot.cmd.gate2_sensor, slot.cmd.gate1_sensor} = sensors;
        slot.drain_first = drain;
        cmd_backlog.push_back(slot);
        total_cmds++;
    endtask

    always @(negedge i_clk) begin : drive_commands
        t_cmd_slot   slot;
        logic        nxt_valid;
        int unsigned idle_pct;
        nxt_valid = i_in_valid;
        case ((cmds_taken / 16) % 4)
            0: idle_pct = 30;
            1: idle_pct = 0;
            2: idle_pct = 60;
            default: idle_pct = 15;
        endcase
        if (cmd_backlog.size() < CALM_TAIL) begin
            idle_pct = 0;
        end
        if (i_rst_n && (!i_in_valid || in_fired)) begin
            nxt_valid = 1'b0;
            if (in_fired && $urandom_range(99) < idle_pct) begin
                in_gap = $urandom_range(13, 1);
            end
            if (in_gap != 0) begin
                in_gap--;
            end else if (cmd_backlog.size() != 0 &&
                         !(cmd_backlog[0].drain_first && pending_replies.size() != 0)) begin
                slot = cmd_backlog.pop_front();
                i_in_data <= slot.cmd;
                nxt_valid = 1'b1;
            end
        end
        i_in_valid <= nxt_valid;
    end

    always @(negedge i_clk) begin : drive_stall
        int unsigned stall_pct;
        case ((replies_seen / 40) % 4)
            0: stall_pct = 10;
            1: stall_pct = 0;
            2: stall_pct = 20;
            default: stall_pct = 5;
        endcase
        if (out_gap == 0 && cmd_backlog.size() >= CALM_TAIL &&
            $urandom_range(99) < stall_pct) begin
            out_gap = $urandom_range(13, 1);
        end
        if (out_gap != 0) begin
            out_gap--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : watch_transfers
        t_out want;
        bit   progress;
        in_fired = i_rst_n && i_in_valid && !o_in_stall;
        out_fired = i_rst_n && o_out_valid && !i_out_stall;
        progress = in_fired || !i_rst_n;
        if (in_fired) begin
            predict_reply(i_in_data);
            cmds_taken++;
        end
        if (out_fired) begin
            replies_seen++;
            if (pending_replies.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) begin
                    $display("Unexpected reply transfer: byte %02h v%b l%b sd%b rs%b st %04h",
                             o_out_data.reply_byte, o_out_data.byte_valid,
                             o_out_data.frame_last, o_out_data.shutdown_request,
                             o_out_data.reset_request, o_out_data.status_word);
                end
            end else begin
                progress = 1'b1;
                want = pending_replies.pop_front();
                if (o_out_data.reply_byte !== want.reply_byte ||
                    o_out_data.byte_valid !== want.byte_valid ||
                    o_out_data.frame_last !== want.frame_last ||
                    o_out_data.shutdown_request !== want.shutdown_request ||
                    o_out_data.reset_request !== want.reset_request ||
                    o_out_data.status_word !== want.status_word) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("Reply %0d mismatch: expected byte %02h v%b l%b sd%b rs%b st %04h",
                                 replies_seen, want.reply_byte, want.byte_valid,
                                 want.frame_last, want.shutdown_request, want.reset_request,
                                 want.status_word);
                        $display("    got byte %02h v%b l%b sd%b rs%b st %04h",
                                 o_out_data.reply_byte, o_out_data.byte_valid,
                                 o_out_data.frame_last, o_out_data.shutdown_request,
                                 o_out_data.reset_request, o_out_data.status_word);
                    end
                end
            end
        end
        if (progress) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
            $display("scanner_command_frame_handler test failed");
            $finish;
        end
    end

    initial begin : run_test
        t_in         c;
        int unsigned pick;
        logic [31:0] args;
        scanner = '0;

        queue_cmd(CMD_QUERY, 32'h0000_0000, 2'b00);
        queue_cmd(CMD_MOTOR, {6'h3F, CODE_ONE, 6'h00, CODE_ONE, 16'hFFFF}, 2'b11);
        queue_cmd(CMD_MOTOR, {6'h15, CODE_KEEP, 6'h2A, CODE_KEEP, 16'h0000}, 2'b01);
        queue_cmd(CMD_MOTOR, {6'h00, CODE_TWO, 6'h3F, CODE_TWO, 16'h1234}, 2'b10);
        queue_cmd(CMD_QUERY, 32'hFFFF_FFFF, 2'b11);
        queue_cmd(CMD_MOTOR, {6'h3F, CODE_KEEP, 6'h3F, CODE_KEEP, 16'hFFFF}, 2'b00);
        queue_cmd(CMD_MOTOR, {6'h3F, CODE_ZERO, 6'h3F, CODE_ZERO, 16'h0000}, 2'b00);
        queue_cmd(CMD_LAMPS, {6'h00, CODE_KEEP, 6'h00, CODE_KEEP, 16'h0000}, 2'b01);
        queue_cmd(CMD_QUERY, 32'h0000_0000, 2'b10);
        queue_cmd(CMD_LAMPS, {6'h3F, CODE_ZERO, 6'h3F, CODE_TWO, 16'hFFFF}, 2'b11);
        queue_cmd(CMD_LAMPS, {6'h2A, CODE_ONE, 6'h15, CODE_ONE, 16'h0000}, 2'b00);
        queue_cmd(CMD_LAMPS, {6'h00, CODE_TWO, 6'h00, CODE_ZERO, 16'h0000}, 2'b00);
        queue_cmd(CMD_MOTOR, {6'h00, CODE_ONE, 6'h00, CODE_TWO, 16'h0000}, 2'b00);
        queue_cmd(CMD_CHECK, 32'h0000_0000, 2'b01);
        queue_cmd(CMD_QUERY, 32'h0000_0000, 2'b00);
        queue_cmd(CMD_CHECK, 32'hFFFF_FFFF, 2'b10);
        queue_cmd(CMD_CHECK, 32'h0000_0000, 2'b11);
        queue_cmd(CMD_CHECK, 32'h0000_0000, 2'b00);
        queue_cmd(CMD_SHUTDOWN, {SHUTDOWN_KEY, KEY_BYTE}, 2'b00);
        queue_cmd(CMD_SHUTDOWN, {SHUTDOWN_KEY, KEY_BYTE ^ 8'h01}, 2'b11);
        queue_cmd(CMD_RESET, {RESET_KEY, KEY_BYTE}, 2'b10);
        queue_cmd(CMD_RESET, {RESET_KEY ^ 24'h000100, KEY_BYTE}, 2'b01);
        queue_cmd(8'h00, 32'h0000_0000, 2'b00);
        queue_cmd(8'hFF, 32'hFFFF_FFFF, 2'b11);
        queue_cmd(CMD_QUERY, 32'h5A5A_A5A5, 2'b11, 1'b1);

        for (int n = 0; n < RANDOM_CMDS; n++) begin
            pick = $urandom_range(99);
            args = $urandom;
            if (pick < 20) begin
                c.frame_head = CMD_QUERY;
            end else if (pick < 40) begin
                c.frame_head = CMD_MOTOR;
            end else if (pick < 60) begin
                c.frame_head = CMD_LAMPS;
            end else if (pick < 72) begin
                c.frame_head = CMD_CHECK;
            end else if (pick < 88) begin
                c.frame_head = (pick < 80) ? CMD_SHUTDOWN : CMD_RESET;
                args = {(pick < 80) ? SHUTDOWN_KEY : RESET_KEY, KEY_BYTE};
                if ($urandom_range(1)) begin
                    args = args ^ (32'd1 << $urandom_range(31));
                end
            end else begin
                c.frame_head = 8'($urandom_range(255));
            end
            queue_cmd(c.frame_head, args, 2'($urandom_range(3)), n == RANDOM_CMDS / 2);
        end

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (cmds_taken != total_cmds || pending_replies.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Sent %0d commands and checked %0d reply transfers with %0d mismatches.",
                 cmds_taken, replies_seen, mismatch_cnt);
        $display("Seen: %0d shutdowns, %0d resets, %0d faulted self-checks, %0d unknown heads.",
                 shutdown_cnt, reset_cnt, fault_cnt, unknown_cnt);
        if (mismatch_cnt == 0) begin
            $display("scanner_command_frame_handler test passed");
        end else begin
            $display("scanner_command_frame_handler test failed");
        end
        $finish;
    end

endmodule

### files.f
rtl/scfh_pkg.sv
rtl/scfh_cmd_decode.sv
rtl/scanner_command_frame_handler.sv
test/tb_top.sv
